// ===== hw/rtl/btp_pkg.sv =====
// types, constants and the thinning decision shared by the thinning pass blocks
`timescale 1ns / 1ps

package btp_pkg;

  localparam int LW_W       = 11;
  localparam int LW_MIN     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 1'b1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd1024;
  localparam logic            SMOOTHING_RST  = 1'b1;

  // job queue between classifier and decision side
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  localparam int TABLE_DEPTH = 48;

  localparam logic [31:0] THIN_TABLE [TABLE_DEPTH] = '{
    32'o00075400340, 32'o00000200000, 32'o00000200000, 32'o00000000000,
    32'o00074600362, 32'o00074600363, 32'o00000000000, 32'o00000000000,
    32'o36475372364, 32'o00000000000, 32'o00175200765, 32'o00000000000,
    32'o36074170360, 32'o36074170360, 32'o00074000360, 32'o00074000360,
    32'o00000200000, 32'o00000200001, 32'o00000200001, 32'o00000200001,
    32'o00074600363, 32'o00074600363, 32'o00074600363, 32'o00074600363,
    32'o00175200765, 32'o00175200765, 32'o00175200765, 32'o00175200765,
    32'o00303601417, 32'o00303601417, 32'o00303601417, 32'o00303601417,
    32'o00000000000, 32'o00000200001, 32'o00000200001, 32'o00000000000,
    32'o00074600363, 32'o00074600363, 32'o00000000000, 32'o00000000000,
    32'o00175200765, 32'o00000000000, 32'o00175200765, 32'o00000000000,
    32'o00000000000, 32'o00000000000, 32'o00000000000, 32'o00000000000
  };

  // one classified item: new window column (bit0 up, bit1 centre, bit2 down)
  typedef struct packed {
    logic [2:0] newcol;
    logic       first;
    logic       last;
  } btp_job_t;

  localparam int JOB_W = $bits(btp_job_t);

  // three-slot row rotation
  function automatic logic [1:0] slot_next(input logic [1:0] s);
    logic [1:0] r;
    r = (s == 2'd2) ? 2'd0 : s + 2'd1;
    return r;
  endfunction

  // win: bits 0..2 left column (ul,l,dl), bits 3..5 centre column (u,c,d)
  function automatic logic thin_delete(input logic [5:0] win, input logic [2:0] nc,
                                       input logic up_kept, input logic prev,
                                       input logic smooth);
    logic        ul, l, dl, u, c, d, ur, r, dr, up_gone;
    logic [5:0]  idx;
    logic [4:0]  bsel;
    logic [31:0] word;
    logic        del;
    ul = win[0];
    l  = win[1];
    dl = win[2];
    u  = win[3];
    c  = win[4];
    d  = win[5];
    ur = nc[0];
    r  = nc[1];
    dr = nc[2];
    up_gone = u & ~up_kept;
    idx  = {1'b0, u, 4'b0000} + {1'b0, up_gone, 4'b0000} + {2'b00, l, r, ul, ur};
    bsel = {smooth, prev, d, dl, dr};
    word = THIN_TABLE[idx];
    del  = 1'b0;
    if (c && !(u && l && r && d) && (word != 32'd0)) begin
      del = word[bsel];
    end
    return del;
  endfunction

endpackage

// ===== hw/rtl/btp_if.sv =====
// stream interfaces for source pixels and thinned results
`timescale 1ns / 1ps

interface btp_in_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface btp_out_if;
  logic valid;
  logic ready;
  logic out_pixel;
  logic removed;
  logic row_end;

  modport source (output valid, output out_pixel, output removed, output row_end, input ready);
  modport sink   (input valid, input out_pixel, input removed, input row_end, output ready);
endinterface

// ===== hw/rtl/btp_front.sv =====
// front end: row counting, three source row stores and item classification
`timescale 1ns / 1ps

module btp_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  btp_in_if.sink                        in_if,
  input  logic [btp_pkg::LW_W-1:0]      line_width,
  input  logic [btp_pkg::Q_LVL_W-1:0]   q_level,
  output logic                          push,
  output btp_pkg::btp_job_t             job,
  output logic [CW-1:0]                 job_col
);

  localparam int CMP_W = (CW + 1 > btp_pkg::LW_W) ? CW + 1 : btp_pkg::LW_W;
  localparam int Q_LVL_W_P1 = btp_pkg::Q_LVL_W + 1;

  logic [CW-1:0]    col_r, col_nxt;
  logic [1:0]       rows_r, rows_nxt;
  logic [1:0]       sel_r, sel_nxt;

  logic             a_valid_r;
  logic [CW-1:0]    a_col_r;
  logic             a_first_r;
  logic             a_last_r;
  logic             a_pix_r;
  logic             a_rows2_r;
  logic [1:0]       a_sel_r;
  logic [2:0]       rd_r;

  logic             accept;
  logic [CW-1:0]    c_eff;
  logic [1:0]       rows_eff;
  logic [CMP_W-1:0] lw_ext;
  logic [CMP_W-1:0] lw_eff;
  logic             last;
  logic [1:0]       up_slot;
  logic [1:0]       ctr_slot;
  logic [Q_LVL_W_P1-1:0] used;

  // the staged item always lands in the queue next cycle, so count it as used
  assign used        = Q_LVL_W_P1'(q_level) + Q_LVL_W_P1'(a_valid_r);
  assign in_if.ready = used < Q_LVL_W_P1'(btp_pkg::Q_DEPTH);
  assign accept      = in_if.valid & in_if.ready;

  assign c_eff    = in_if.frame_start ? '0 : col_r;
  assign rows_eff = in_if.frame_start ? 2'd0 : rows_r;

  always_comb begin
    lw_ext = CMP_W'(line_width);
    if (lw_ext < CMP_W'(btp_pkg::LW_MIN)) begin
      lw_eff = CMP_W'(btp_pkg::LW_MIN);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      lw_eff = CMP_W'(MAX_WIDTH);
    end else begin
      lw_eff = lw_ext;
    end
  end

  assign last = (CMP_W'(c_eff) + CMP_W'(1)) >= lw_eff;

  always_comb begin
    col_nxt  = col_r;
    rows_nxt = rows_r;
    sel_nxt  = sel_r;
    if (accept) begin
      if (last) begin
        col_nxt  = '0;
        rows_nxt = (rows_eff == 2'd2) ? rows_eff : rows_eff + 2'd1;
        sel_nxt  = btp_pkg::slot_next(sel_r);
      end else begin
        col_nxt  = c_eff + CW'(1);
        rows_nxt = rows_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      rows_r    <= 2'd0;
      sel_r     <= 2'd0;
      a_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      rows_r    <= rows_nxt;
      sel_r     <= sel_nxt;
      a_valid_r <= accept && (rows_eff != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r   <= c_eff;
      a_first_r <= c_eff != '0;
      a_last_r  <= last;
      a_pix_r   <= in_if.pixel;
      a_rows2_r <= rows_eff == 2'd2;
      a_sel_r   <= sel_r;
    end
  end

  // one store per row slot: the slot taking the new row writes, the others read
  for (genvar k = 0; k < 3; k++) begin : g_row
    logic row_mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (accept) begin
        if (sel_r == 2'(k)) begin
          row_mem[c_eff] <= in_if.pixel;
        end else begin
          rd_r[k] <= row_mem[c_eff];
        end
      end
    end
  end

  assign up_slot  = btp_pkg::slot_next(a_sel_r);
  assign ctr_slot = btp_pkg::slot_next(up_slot);

  assign push       = a_valid_r;
  assign job.newcol = {a_pix_r, rd_r[ctr_slot], a_rows2_r & rd_r[up_slot]};
  assign job.first  = a_first_r;
  assign job.last   = a_last_r;
  assign job_col    = a_col_r;

endmodule

// ===== hw/rtl/btp_fifo.sv =====
// short job queue between front end and decision side
`timescale 1ns / 1ps

module btp_fifo #(
  parameter int W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [W-1:0]                wdata,
  input  logic                        pop,
  output logic [W-1:0]                rdata,
  output logic                        empty,
  output logic [btp_pkg::Q_LVL_W-1:0] level
);

  logic [W-1:0]                data_r [btp_pkg::Q_DEPTH];
  logic [btp_pkg::Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [btp_pkg::Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [btp_pkg::Q_LVL_W-1:0] cnt_r, cnt_nxt;
  logic                        do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign empty  = cnt_r == '0;
  assign level  = cnt_r;
  assign rdata  = data_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + btp_pkg::Q_PTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + btp_pkg::Q_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + btp_pkg::Q_LVL_W'(push) - btp_pkg::Q_LVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/btp_back.sv =====
// decision side: window tracking, table decision, thinned row store, result register
`timescale 1ns / 1ps

module btp_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  btp_pkg::btp_job_t job,
  input  logic [CW-1:0]     job_col,
  input  logic              q_empty,
  input  logic              smoothing,
  output logic              pop,
  btp_out_if.source         out_if
);

  logic [5:0]    win_r;
  logic          phase_r;
  logic          prev_r;

  logic          op_valid_r;
  logic [CW-1:0] op_j_r;
  logic [5:0]    op_win_r;
  logic [2:0]    op_nc_r;
  logic          op_last_r;
  logic          kept_r;

  logic          out_valid_r;
  logic          out_pixel_r;
  logic          removed_r;
  logic          row_end_r;

  logic [5:0]    win_pre;
  logic [5:0]    win_post;
  logic          want1;
  logic          want2;
  logic          emit;
  logic [CW-1:0] sel_j;
  logic [5:0]    sel_win;
  logic [2:0]    sel_nc;
  logic          op_fire;
  logic          op_load;
  logic          prev_use;
  logic          del;

  logic thin_mem [MAX_WIDTH];

  // a job at column zero always follows a row end or frame start: window empty
  assign win_pre  = (job_col == '0) ? 6'd0 : win_r;
  assign win_post = {job.newcol, win_pre[5:3]};

  assign want1 = job.first && !phase_r;
  assign want2 = job.last;
  assign emit  = !q_empty && (want1 || want2);

  always_comb begin
    if (want1) begin
      sel_j   = job_col - CW'(1);
      sel_win = win_pre;
      sel_nc  = job.newcol;
    end else begin
      sel_j   = job_col;
      sel_win = win_post;
      sel_nc  = 3'd0;
    end
  end

  assign op_fire = op_valid_r && (!out_valid_r || out_if.ready);
  assign op_load = emit && (!op_valid_r || op_fire);
  assign pop     = !q_empty && (!(want1 || want2) || (op_load && !(want1 && want2)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= 6'd0;
      phase_r    <= 1'b0;
      prev_r     <= 1'b0;
      op_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        win_r   <= win_post;
        phase_r <= 1'b0;
      end else if (op_load && want1 && want2) begin
        phase_r <= 1'b1;
      end
      if (op_fire) begin
        prev_r <= del;
      end
      if (op_load) begin
        op_valid_r <= 1'b1;
      end else if (op_fire) begin
        op_valid_r <= 1'b0;
      end
      if (op_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      op_j_r    <= sel_j;
      op_win_r  <= sel_win;
      op_nc_r   <= sel_nc;
      op_last_r <= !want1;
      kept_r    <= thin_mem[sel_j];
    end
    if (op_fire) begin
      thin_mem[op_j_r] <= op_win_r[4] & ~del;
    end
  end

  // the first decision of a row never sees a deletion to its left
  assign prev_use = (op_j_r == '0) ? 1'b0 : prev_r;
  assign del      = btp_pkg::thin_delete(op_win_r, op_nc_r, kept_r, prev_use, smoothing);

  always_ff @(posedge clk) begin
    if (op_fire) begin
      out_pixel_r <= op_win_r[4] & ~del;
      removed_r   <= del;
      row_end_r   <= op_last_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_pixel = out_pixel_r;
  assign out_if.removed   = removed_r;
  assign out_if.row_end   = row_end_r;

endmodule

// ===== hw/rtl/binary_thinning_pass_core.sv =====
// top level of one raster thinning pass over a binary pixel stream
//
//   port     dir   payload                        handshake
//   in_if    in    pixel, frame_start             valid / ready
//   out_if   out   out_pixel, removed, row_end    valid / ready
//   cfg_*    in    cfg_idx, cfg_wdata             cfg_we, no wait
//
// up to one item is taken per cycle; each row of line_width items gives line_width results
// (none for the first row of a frame), two of them on the last column
// an item's first result passes, in order, the row store read stage, the job queue, the
// decision stage with the thinned row store read and the result register
// the back side makes one decision per item past column zero and a second one on the row end,
// so it falls behind the input at every row end; the four-entry job queue rides this out
// until it fills, then the input stalls at row ends; output stalls back up through the queue
// reset is synchronous and clears counters and handshake state; no clearing pass
`timescale 1ns / 1ps

module binary_thinning_pass_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  btp_in_if.sink                            in_if,
  btp_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [btp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [btp_pkg::LW_W-1:0]          cfg_wdata
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW  = btp_pkg::JOB_W + CW;

  logic [btp_pkg::LW_W-1:0]    line_width_r;
  logic                        smoothing_r;

  logic                        push;
  btp_pkg::btp_job_t           f_job;
  logic [CW-1:0]               f_col;
  logic [QW-1:0]               q_rdata;
  logic                        q_empty;
  logic [btp_pkg::Q_LVL_W-1:0] q_level;
  logic                        pop;
  btp_pkg::btp_job_t           b_job;
  logic [CW-1:0]               b_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= btp_pkg::LINE_WIDTH_RST;
      smoothing_r  <= btp_pkg::SMOOTHING_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        btp_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata;
        btp_pkg::CFG_SMOOTHING:  smoothing_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  btp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .line_width (line_width_r),
    .q_level    (q_level),
    .push       (push),
    .job        (f_job),
    .job_col    (f_col)
  );

  btp_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_col, f_job}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  assign b_job = q_rdata[btp_pkg::JOB_W-1:0];
  assign b_col = q_rdata[QW-1:btp_pkg::JOB_W];

  btp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (b_job),
    .job_col   (b_col),
    .q_empty   (q_empty),
    .smoothing (smoothing_r),
    .pop       (pop),
    .out_if    (out_if)
  );

endmodule

// ===== verif/thinning_checker.sv =====
// result checker for the thinning pass: predicts the thinned stream and compares it
`timescale 1ns / 1ps

module thinning_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  btp_in_if                             in_ch,
  btp_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [btp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [btp_pkg::LW_W-1:0]      cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import btp_pkg::*;

  typedef struct packed {
    logic pix;
    logic removed;
    logic row_end;
  } thin_res_t;

  // deletion words: index from the upper and side neighbours, bit from the lower ones, prev_del and smoothing
  localparam logic [31:0] DELETE_WORDS [48] = '{
    32'o00075400340, 32'o00000200000, 32'o00000200000, 32'o00000000000,
    32'o00074600362, 32'o00074600363, 32'o00000000000, 32'o00000000000,
    32'o36475372364, 32'o00000000000, 32'o00175200765, 32'o00000000000,
    32'o36074170360, 32'o36074170360, 32'o00074000360, 32'o00074000360,
    32'o00000200000, 32'o00000200001, 32'o00000200001, 32'o00000200001,
    32'o00074600363, 32'o00074600363, 32'o00074600363, 32'o00074600363,
    32'o00175200765, 32'o00175200765, 32'o00175200765, 32'o00175200765,
    32'o00303601417, 32'o00303601417, 32'o00303601417, 32'o00303601417,
    32'o00000000000, 32'o00000200001, 32'o00000200001, 32'o00000000000,
    32'o00074600363, 32'o00074600363, 32'o00000000000, 32'o00000000000,
    32'o00175200765, 32'o00000000000, 32'o00175200765, 32'o00000000000,
    32'o00000000000, 32'o00000000000, 32'o00000000000, 32'o00000000000
  };

  logic [LW_W-1:0] line_width;
  logic            smoothing;
  bit              src_rows   [3][MAX_WIDTH];
  bit              kept_above [MAX_WIDTH];
  int              slot;
  int              rows_seen;
  int              col;
  logic [5:0]      win;
  bit              prev_del;
  thin_res_t       thinned_q [$];
  int              n_fail;
  int              n_checked;

  // win: bits 0..2 left column (ul, l, dl), bits 3..5 centre column (u, c, d)
  function automatic void decide_col(int j, logic [2:0] nc, logic last_col);
    logic        ul, l, dl, u, c, d, ur, r, dr, gone, del;
    int          idx, bsel;
    logic [31:0] word;
    {d, c, u, dl, l, ul} = win;
    {dr, r, ur} = nc;
    del = 1'b0;
    if (c && !(u && l && r && d)) begin
      gone = u && !kept_above[j];
      idx  = 16 * int'(u) + 8 * int'(l) + 4 * int'(r) + 16 * int'(gone)
             + 2 * int'(ul) + int'(ur);
      word = DELETE_WORDS[idx];
      if (word != 32'd0) begin
        bsel = 16 * int'(smoothing) + 8 * int'(prev_del) + 4 * int'(d) + 2 * int'(dl)
               + int'(dr);
        del = word[bsel];
      end
    end
    prev_del = del;
    kept_above[j] = c & ~del;
    thinned_q.push_back(thin_res_t'{c & ~del, del, last_col});
  endfunction

  function automatic void predict_item(logic pix, logic fs);
    int         lw, c, up_s, ctr_s;
    logic       last, ub;
    logic [2:0] nc;
    lw = int'(line_width);
    if (lw < LW_MIN) lw = LW_MIN;
    if (lw > MAX_WIDTH) lw = MAX_WIDTH;
    if (fs) begin
      col = 0;
      rows_seen = 0;
      win = '0;
      prev_del = 1'b0;
    end
    c = col;
    // a column at or past a lowered width closes the row
    last = (c + 1 >= lw);
    up_s = (slot + 1) % 3;
    ctr_s = (slot + 2) % 3;
    src_rows[slot][c] = pix;
    if (rows_seen >= 1) begin
      ub = (rows_seen >= 2) ? src_rows[up_s][c] : 1'b0;
      nc = {pix, src_rows[ctr_s][c], ub};
      if (c >= 1) decide_col(c - 1, nc, 1'b0);
      win = {nc, win[5:3]};
      if (last) decide_col(c, 3'b000, 1'b1);
    end
    if (last) begin
      col = 0;
      win = '0;
      prev_del = 1'b0;
      slot = (slot + 1) % 3;
      if (rows_seen < 2) rows_seen++;
    end else begin
      col = c + 1;
    end
  endfunction

  function automatic void flag_field(string field, logic want, logic seen);
    if (seen !== want) begin
      n_fail++;
      if (n_fail <= 30)
        $display("%0t: result %0d %s expected %b got %b", $time, n_checked, field, want,
                 seen);
    end
  endfunction

  always @(posedge clk) begin
    thin_res_t want;
    if (!rst_n) begin
      line_width = LINE_WIDTH_RST;
      smoothing = SMOOTHING_RST;
      slot = 0;
      rows_seen = 0;
      col = 0;
      win = '0;
      prev_del = 1'b0;
      thinned_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (thinned_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 30)
            $display("%0t: unexpected result pixel=%b removed=%b row_end=%b, expected none",
                     $time, out_ch.out_pixel, out_ch.removed, out_ch.row_end);
        end else begin
          want = thinned_q.pop_front();
          flag_field("out_pixel", want.pix, out_ch.out_pixel);
          flag_field("removed", want.removed, out_ch.removed);
          flag_field("row_end", want.row_end, out_ch.row_end);
          n_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.pixel, in_ch.frame_start);
      if (cfg_we) begin
        if (cfg_idx == CFG_LINE_WIDTH) line_width = cfg_wdata;
        else if (cfg_idx == CFG_SMOOTHING) smoothing = cfg_wdata[0];
      end
    end
    fail_count <= n_fail;
    pending <= thinned_q.size();
    checked <= n_checked;
  end

endmodule

// ===== verif/tb.sv =====
// testbench top for the thinning pass: clock, reset, pixel frames, config and verdict
`timescale 1ns / 1ps

module tb;
  import btp_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int RUN_LIMIT     = 1000000;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 12;

  // directed shapes on a 3-wide image, lsb first, last row zero to flush
  localparam logic [11:0] SOLID_BLOCK = 12'b000_111_111_111;
  localparam logic [11:0] CROSS_SHAPE = 12'b000_010_111_010;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LW_W-1:0]      cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int cycle_cnt;
  int items_sent;
  int frames_sent;
  int rand_goal;
  bit no_gaps;

  logic [LW_W-1:0] cur_lw;
  logic [LW_W-1:0] new_lw;
  int              old_eff, w, pct, rows, kind, noise;
  bit              reconf, mark;

  btp_in_if  in_ch ();
  btp_out_if out_ch ();

  binary_thinning_pass_core #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  thinning_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure: mostly short open stretches with some long ones, mostly short stalls
  initial begin
    int hi, lo, r;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      if (r < 40) lo = 0;
      else if (r < 85) lo = $urandom_range(1, 3);
      else if (r < 96) lo = $urandom_range(4, 12);
      else lo = $urandom_range(20, 50);
      out_ch.ready <= 1'b1;
      repeat (hi) @(posedge clk);
      if (lo > 0) begin
        out_ch.ready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
    end
  end

  function automatic int eff_width(logic [LW_W-1:0] lw);
    int v;
    v = int'(lw);
    if (v < LW_MIN) v = LW_MIN;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LW_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return LW_W'($urandom_range(0, 2));
    if (r < 55) return LW_W'($urandom_range(3, 8));
    if (r < 85) return LW_W'($urandom_range(9, 32));
    return LW_W'($urandom_range(33, 120));
  endfunction

  function automatic int pick_density();
    int r;
    r = $urandom_range(0, 4);
    case (r)
      0: return 10;
      1: return 40;
      2: return 65;
      3: return 85;
      default: return 100;
    endcase
  endfunction

  task automatic send_item(logic pix, logic fs);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= pix;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_row(int density, bit fs_first, int len, int fs_noise);
    for (int c = 0; c < len; c++)
      send_item($urandom_range(0, 99) < density,
                (fs_first && c == 0) || ($urandom_range(0, 99) < fs_noise));
  endtask

  task automatic send_shape(logic [11:0] pat);
    for (int i = 0; i < 12; i++) send_item(pat[i], i == 0);
  endtask

  // input held off until every expected item is out, then the pipe drains
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LW_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LINE_WIDTH) cur_lw = data;
  endtask

  task automatic configure(logic [LW_W-1:0] lw, logic smooth);
    settle();
    write_reg(CFG_LINE_WIDTH, lw);
    write_reg(CFG_SMOOTHING, {{(LW_W-1){1'b0}}, smooth});
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_LINE_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pixel <= 1'b0;
    in_ch.frame_start <= 1'b0;
    cur_lw = LINE_WIDTH_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: width written as zero acts as the minimum of three
    configure('0, 1'b1);
    send_shape(SOLID_BLOCK);
    send_shape(CROSS_SHAPE);
    frames_sent += 2;

    // a full-width row with an over-range width, then the width drops below the column
    configure('1, 1'b1);
    no_gaps = 1'b1;
    send_row(50, 1'b1, MAX_WIDTH, 0);
    settle();
    write_reg(CFG_SMOOTHING, '0);
    no_gaps = 1'b0;
    send_row(60, 1'b0, 40, 0);
    settle();
    write_reg(CFG_LINE_WIDTH, LW_W'(30));
    send_row(70, 1'b0, 1, 0);
    for (int r = 0; r < 3; r++) send_row(65, 1'b0, 30, 0);
    send_row(0, 1'b0, 30, 0);
    frames_sent++;

    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      new_lw = pick_width();
      old_eff = eff_width(cur_lw);
      reconf = ($urandom_range(0, 99) < 60);
      if (reconf) configure(new_lw, 1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 14) == 0) settle();
      w = eff_width(cur_lw);
      // continuing without a frame start is only safe when the width did not grow
      mark = (w > old_eff) || ($urandom_range(0, 9) != 0);
      pct = pick_density();
      no_gaps = ($urandom_range(0, 3) == 0);
      if (w <= 8) rows = $urandom_range(3, 12);
      else if (w <= 32) rows = $urandom_range(2, 6);
      else rows = $urandom_range(2, 3);
      kind = $urandom_range(0, 99);
      noise = (kind >= 90) ? 3 : 0;
      for (int r = 0; r < rows; r++) send_row(pct, mark && r == 0, w, noise);
      if (kind < 80) send_row(0, 1'b0, w, 0);
      else if (kind < 90) send_row(pct, 1'b0, $urandom_range(1, w - 1), 0);
      frames_sent++;
    end

    settle();
    $display("covered %0d pixel items in %0d frames, %0d thinned results checked",
             items_sent, frames_sent, checked);
    $display("widths from clamped minimum to clamped maximum, mid-row width drop, "
             , "smoothing on and off");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
